>>> rtl/core/go_to_point_steering_core_macros.svh
// Assertion shorthands shared by the checker.
`ifndef GO_TO_POINT_STEERING_CORE_MACROS_SVH
`define GO_TO_POINT_STEERING_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GTP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/gtp_pkg.sv
`timescale 1ns / 1ps
package gtp_pkg;

  localparam int POS_W         = 16;
  localparam int DIFF_W        = POS_W + 1;
  localparam int HD_W          = 15;
  localparam int XY_W          = 28;
  localparam int Z_W           = 24;
  localparam int SQ_W          = 2 * DIFF_W;
  localparam int ROOT_W        = DIFF_W;
  localparam int REM_W         = ROOT_W + 3;
  localparam int CORDIC_STAGES = 16;
  localparam int NCELL         = ROOT_W;
  localparam int STG_W         = 5;
  localparam int TURN_W        = 18;
  localparam int SPEED_W       = 17;
  localparam int AGAIN_W       = 12;
  localparam int LGAIN_W       = 10;
  localparam int GATE_W        = 14;
  localparam int TOL_W         = 16;

  localparam logic signed [Z_W-1:0] HALF_PI_Q20 = 24'sd1647099;

  typedef enum logic [2:0] {
    REG_GOAL_X    = 3'd0,
    REG_GOAL_Y    = 3'd1,
    REG_ANG_GAIN  = 3'd2,
    REG_LIN_GAIN  = 3'd3,
    REG_HEAD_GATE = 3'd4,
    REG_REACH_TOL = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] goal_x;
    logic signed [POS_W-1:0] goal_y;
    logic [AGAIN_W-1:0]      angular_gain;
    logic [LGAIN_W-1:0]      linear_gain;
    logic [GATE_W-1:0]       heading_gate;
    logic [2*TOL_W-1:0]      tol_sq;
  } cfg_t;

  // One word in flight along the cell row.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [SQ_W-1:0]        rad;
    logic [REM_W-1:0]       rem;
    logic [ROOT_W-1:0]      root;
    logic signed [HD_W-1:0] hd;
    logic                   reached;
  } cell_t;

  // atan(2^-i) with 20 fraction bits, rounded.
  function automatic logic signed [Z_W-1:0] atan_q20(input logic [STG_W-1:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:  r = 24'sd823550;
      5'd1:  r = 24'sd486170;
      5'd2:  r = 24'sd256879;
      5'd3:  r = 24'sd130396;
      5'd4:  r = 24'sd65451;
      5'd5:  r = 24'sd32757;
      5'd6:  r = 24'sd16383;
      5'd7:  r = 24'sd8192;
      5'd8:  r = 24'sd4096;
      5'd9:  r = 24'sd2048;
      5'd10: r = 24'sd1024;
      5'd11: r = 24'sd512;
      5'd12: r = 24'sd256;
      5'd13: r = 24'sd128;
      5'd14: r = 24'sd64;
      5'd15: r = 24'sd32;
      5'd16: r = 24'sd16;
      5'd17: r = 24'sd8;
      5'd18: r = 24'sd4;
      5'd19: r = 24'sd2;
      5'd20: r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/gtp_front.sv
`timescale 1ns / 1ps
module gtp_front
  import gtp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] pose_x,
  input  logic signed [POS_W-1:0] pose_y,
  input  logic signed [HD_W-1:0]  heading,
  input  cfg_t                    cfg,
  output logic                    out_valid,
  input  logic                    out_ready,
  output cell_t                   out
);

  logic                     v1, v2;
  logic                     r1, r2;
  logic signed [DIFF_W-1:0] dx1, dy1;
  logic signed [HD_W-1:0]   hd1, hd2;
  logic [SQ_W-1:0]          sqx, sqy;
  logic signed [XY_W-1:0]   x2, y2;
  logic signed [Z_W-1:0]    z2;

  logic [DIFF_W-1:0]        adx, ady;
  logic signed [XY_W-1:0]   x0, y0, xr, yr;
  logic signed [Z_W-1:0]    zr;
  logic [SQ_W-1:0]          sum;

  assign r2       = !out_valid || out_ready;
  assign r1       = !v2 || r2;
  assign in_ready = !v1 || r1;

  // Offset to goal
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dx1 <= {cfg.goal_x[POS_W-1], cfg.goal_x} - {pose_x[POS_W-1], pose_x};
      dy1 <= {cfg.goal_y[POS_W-1], cfg.goal_y} - {pose_y[POS_W-1], pose_y};
      hd1 <= heading;
    end
  end

  // Squares and the quarter-turn pre-rotation
  always_comb begin
    adx = dx1[DIFF_W-1] ? DIFF_W'(-dx1) : DIFF_W'(dx1);
    ady = dy1[DIFF_W-1] ? DIFF_W'(-dy1) : DIFF_W'(dy1);
    x0  = {{(XY_W-DIFF_W-8){dx1[DIFF_W-1]}}, dx1, 8'b0};
    y0  = {{(XY_W-DIFF_W-8){dy1[DIFF_W-1]}}, dy1, 8'b0};
    xr  = x0;
    yr  = y0;
    zr  = '0;
    if (dx1[DIFF_W-1]) begin
      if (!dy1[DIFF_W-1]) begin
        xr = y0;
        yr = -x0;
        zr = HALF_PI_Q20;
      end else begin
        xr = -y0;
        yr = x0;
        zr = -HALF_PI_Q20;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r1) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && v1) begin
      sqx <= SQ_W'(adx) * SQ_W'(adx);
      sqy <= SQ_W'(ady) * SQ_W'(ady);
      x2  <= xr;
      y2  <= yr;
      z2  <= zr;
      hd2 <= hd1;
    end
  end

  // Squared distance and reach test; load the first cell word
  assign sum = sqx + sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r2) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v2) begin
      out.x       <= x2;
      out.y       <= y2;
      out.z       <= z2;
      out.rad     <= sum;
      out.rem     <= '0;
      out.root    <= '0;
      out.hd      <= hd2;
      out.reached <= sum <= SQ_W'(cfg.tol_sq);
    end
  end

endmodule

>>> rtl/core/gtp_cell.sv
`timescale 1ns / 1ps
module gtp_cell
  import gtp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [STG_W-1:0] stage,
  input  logic             in_valid,
  output logic             in_ready,
  input  cell_t            in,
  output logic             out_valid,
  input  logic             out_ready,
  output cell_t            out
);

  cell_t                  nxt;
  logic signed [XY_W-1:0] xs, ys;
  logic [REM_W-1:0]       rem2, trial;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    nxt = in;
    // One CORDIC vectoring micro-rotation
    xs  = in.x >>> stage;
    ys  = in.y >>> stage;
    if (stage < STG_W'(CORDIC_STAGES)) begin
      if (!in.y[XY_W-1]) begin
        nxt.x = in.x + ys;
        nxt.y = in.y - xs;
        nxt.z = in.z + atan_q20(stage);
      end else begin
        nxt.x = in.x - ys;
        nxt.y = in.y + xs;
        nxt.z = in.z - atan_q20(stage);
      end
    end
    // One root bit: bring down two radicand bits, trial subtract
    rem2    = {in.rem[REM_W-3:0], in.rad[SQ_W-1 -: 2]};
    trial   = {1'b0, in.root, 2'b01};
    nxt.rad = {in.rad[SQ_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      nxt.rem  = rem2 - trial;
      nxt.root = {in.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = rem2;
      nxt.root = {in.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out <= nxt;
    end
  end

endmodule

>>> rtl/core/gtp_back.sv
`timescale 1ns / 1ps
module gtp_back
  import gtp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cell_t                    in,
  input  cfg_t                     cfg,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TURN_W-1:0] turn_rate,
  output logic [SPEED_W-1:0]       forward_speed,
  output logic                     goal_reached
);

  localparam int PA_W = AGAIN_W + 1 + DIFF_W;
  localparam int PL_W = LGAIN_W + ROOT_W;
  localparam int TF_W = PA_W - 8;
  localparam int SP_W = PL_W - 8;

  logic                     v1, v2;
  logic                     r1, r2;
  logic signed [DIFF_W-1:0] diff1;
  logic [ROOT_W-1:0]        dist1;
  logic                     reach1, reach2;
  logic signed [PA_W-1:0]   prod_a;
  logic [PL_W-1:0]          prod_l;

  logic [Z_W-1:0]           zr;
  logic signed [15:0]       br;
  logic signed [PA_W-1:0]   tsum;
  logic signed [TF_W-1:0]   tf;
  logic [TF_W-1:0]          tabs;
  logic [PL_W-1:0]          lsum;
  logic [SP_W-1:0]          spd;
  logic                     gate_open;
  logic signed [TURN_W-1:0] tsat;
  logic [SPEED_W-1:0]       ssat;

  assign r2       = !out_valid || out_ready;
  assign r1       = !v2 || r2;
  assign in_ready = !v1 || r1;

  // Round the bearing to 12 fraction bits and take off the heading
  always_comb begin
    zr = in.z + Z_W'(128);
    br = zr[Z_W-1:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      diff1  <= {br[15], br} - {{(DIFF_W-HD_W){in.hd[HD_W-1]}}, in.hd};
      dist1  <= in.root;
      reach1 <= in.reached;
    end
  end

  // Gains
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r1) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && v1) begin
      prod_a <= PA_W'($signed({1'b0, cfg.angular_gain})) * PA_W'(diff1);
      prod_l <= PL_W'(cfg.linear_gain) * PL_W'(dist1);
      reach2 <= reach1;
    end
  end

  // Round, gate and saturate
  always_comb begin
    tsum      = prod_a + PA_W'(128);
    tf        = tsum[PA_W-1:8];
    tabs      = tf[TF_W-1] ? TF_W'(-tf) : TF_W'(tf);
    gate_open = tabs < TF_W'(cfg.heading_gate);
    lsum      = prod_l + PL_W'(128);
    spd       = lsum[PL_W-1:8];
    if (tf > TF_W'(131071)) begin
      tsat = 18'sd131071;
    end else if (tf < -TF_W'(131072)) begin
      tsat = -18'sd131072;
    end else begin
      tsat = tf[TURN_W-1:0];
    end
    if (spd > SP_W'(131071)) begin
      ssat = 17'd131071;
    end else begin
      ssat = spd[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r2) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v2) begin
      goal_reached  <= reach2;
      turn_rate     <= reach2 ? '0 : tsat;
      forward_speed <= (reach2 || !gate_open) ? '0 : ssat;
    end
  end

endmodule

>>> rtl/core/go_to_point_steering_core.sv
`timescale 1ns / 1ps
// Path: an accepted s-side word passes 3 front stages, 17 cells and 3 back stages
// before its result shows on m_tvalid. Throughput: one word per cycle unless m_tready
// stalls the output; each cell does one square-root bit and cells 0-15 one CORDIC
// rotation each, so the cell row sets the depth, not the rate.
// Reset (synchronous, active high) clears all valid flags and loads the register defaults.
module go_to_point_steering_core
  import gtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // pose_x[15:0], pose_y[31:16], heading[46:32], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // turn_rate[17:0], forward_speed[34:18], zero
  output logic [0:0]  m_tuser,   // goal_reached[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [POS_W-1:0] goal_x, goal_y;
  logic [AGAIN_W-1:0]      angular_gain;
  logic [LGAIN_W-1:0]      linear_gain;
  logic [GATE_W-1:0]       heading_gate;
  logic [TOL_W-1:0]        reach_tolerance;
  logic [2*TOL_W-1:0]      tol_sq;
  cfg_t                    cfg;
  logic                    wr;

  logic                    cv [0:NCELL];
  logic                    cr [0:NCELL];
  cell_t                   cd [0:NCELL];

  logic signed [TURN_W-1:0] turn_rate;
  logic [SPEED_W-1:0]       forward_speed;
  logic                     goal_reached;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x          <= '0;
      goal_y          <= '0;
      angular_gain    <= 12'd1024;
      linear_gain     <= 10'd256;
      heading_gate    <= 14'd819;
      reach_tolerance <= 16'd26;
    end else if (wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_GOAL_X:    goal_x          <= pwdata[POS_W-1:0];
        REG_GOAL_Y:    goal_y          <= pwdata[POS_W-1:0];
        REG_ANG_GAIN:  angular_gain    <= pwdata[AGAIN_W-1:0];
        REG_LIN_GAIN:  linear_gain     <= pwdata[LGAIN_W-1:0];
        REG_HEAD_GATE: heading_gate    <= pwdata[GATE_W-1:0];
        REG_REACH_TOL: reach_tolerance <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_GOAL_X:    prdata = 32'(unsigned'(goal_x));
      REG_GOAL_Y:    prdata = 32'(unsigned'(goal_y));
      REG_ANG_GAIN:  prdata = 32'(angular_gain);
      REG_LIN_GAIN:  prdata = 32'(linear_gain);
      REG_HEAD_GATE: prdata = 32'(heading_gate);
      REG_REACH_TOL: prdata = 32'(reach_tolerance);
      default:       prdata = '0;
    endcase
  end

  // Squared tolerance, registered behind the tolerance register
  always_ff @(posedge clk) begin
    tol_sq <= (2*TOL_W)'(reach_tolerance) * (2*TOL_W)'(reach_tolerance);
  end

  always_comb begin
    cfg.goal_x       = goal_x;
    cfg.goal_y       = goal_y;
    cfg.angular_gain = angular_gain;
    cfg.linear_gain  = linear_gain;
    cfg.heading_gate = heading_gate;
    cfg.tol_sq       = tol_sq;
  end

  gtp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .pose_x    (s_tdata[15:0]),
    .pose_y    (s_tdata[31:16]),
    .heading   (s_tdata[46:32]),
    .cfg       (cfg),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out       (cd[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    gtp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage     (STG_W'(i)),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in        (cd[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out       (cd[i+1])
    );
  end

  gtp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (cv[NCELL]),
    .in_ready      (cr[NCELL]),
    .in            (cd[NCELL]),
    .cfg           (cfg),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .turn_rate     (turn_rate),
    .forward_speed (forward_speed),
    .goal_reached  (goal_reached)
  );

  assign m_tdata = {5'b0, forward_speed, turn_rate};
  assign m_tuser = goal_reached;

endmodule

>>> rtl/core/gtp_checker.sv
`timescale 1ns / 1ps
`include "go_to_point_steering_core_macros.svh"
module gtp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // Hold a stalled result word
  `GTP_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result word changed")

  // Goal reached forces both commands to zero
  `GTP_ASSERT_SAME(a_reached_zero, m_tvalid && m_tuser[0], m_tdata == 40'd0, "commands not zero at goal")

  // An empty output register lets the whole row advance
  `GTP_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with output empty")

  // No result straight out of reset
  `GTP_ASSERT_SAME(a_reset_clear, $past(rst), !m_tvalid, "result valid right after reset")

endmodule

bind go_to_point_steering_core gtp_checker u_chk (.*);
